FILE: src/cfdb_pkg.sv
`default_nettype none
package cfdb_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OutDataW = 56;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_SEQ     = 8'b0000_0010,
    PH_CMD     = 8'b0000_0100,
    PH_STATE   = 8'b0000_1000,
    PH_LEN     = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CHECK   = 8'b0100_0000,
    PH_SKIP    = 8'b1000_0000
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BADHEAD  = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   data_byte;
    logic [ByteW-1:0]   data_index;
    logic [ByteW-1:0]   seq_number;
    logic [ByteW-1:0]   command_code;
    logic [ByteW-1:0]   state_code;
    logic [ByteW-1:0]   payload_length;
    status_e            status;
  } result_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic             start_of_packet;
  } in_item_t;

endpackage
`default_nettype wire

FILE: src/command_frame_deframer_bcc.sv
// Command frame deframer with an XOR block check.
// Received bytes enter on the s_axis channel, one item per byte; s_axis_tuser
// marks the first byte of a packet. A packet is header, sequence, command,
// state, length L, L payload bytes and a check byte. Each payload byte leaves
// on the m_axis channel as a data item (m_axis_tuser low); the check byte, a
// bad header or a start mark inside a packet gives a summary item
// (m_axis_tuser high) with the captured fields and a status code.
// The expected header byte is written over the cfg channel by the user, only
// while idle; the block does not enforce this. A result passes through the
// input register, where the item waits while the parser steps on it, and the
// result register, which loads the parser's result once it has room. One item
// is accepted in every cycle while the result register has room.
// When the receiver stalls, the result register holds its item and the input
// register fills, so s_axis_tready falls after one more item.
// Reset clears both registers, returns the parser to idle waiting for a start
// mark, and sets the header byte to zero.
`default_nettype none
module command_frame_deframer_bcc (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  wire logic        s_axis_tuser,  // [0] start_of_packet
  // Result item.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] data_byte, [15:8] data_index, [23:16] seq_number,
  // [31:24] command_code, [39:32] state_code, [47:40] payload_length,
  // [49:48] status, [55:50] zero
  output logic [cfdb_pkg::OutDataW-1:0] m_axis_tdata,
  output logic             m_axis_tuser,  // [0] kind
  // Header byte register write.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i
);
  import cfdb_pkg::*;

  logic [ByteW-1:0] header_byte_q;
  in_item_t         in_item;
  in_item_t         item;
  logic             item_valid;
  logic             room;
  logic             step;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  // The register is always writable; software writes it only while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_byte_q <= '0;
    end else if (cfg_valid_i) begin
      header_byte_q <= cfg_data_i;
    end
  end

  assign in_item.byte_value      = s_axis_tdata;
  assign in_item.start_of_packet = s_axis_tuser;

  // The held item is processed once the result register has room for
  // whatever it may produce.
  assign step = item_valid && room;

  cfdb_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .take_i       (step),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  cfdb_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .header_i    (header_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfdb_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {6'b0, out_res.status, out_res.payload_length, out_res.state_code,
                         out_res.command_code, out_res.seq_number, out_res.data_index,
                         out_res.data_byte};
  assign m_axis_tuser = out_res.kind;

endmodule
`default_nettype wire

FILE: src/cfdb_in_stage.sv
`default_nettype none
module cfdb_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cfdb_pkg::in_item_t in_item_i,
  input  wire logic              take_i,
  output logic                   item_valid_o,
  output cfdb_pkg::in_item_t     item_o
);
  import cfdb_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  // The stage takes a new item when empty or when its current item moves on.
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

FILE: src/cfdb_parser.sv
`default_nettype none
module cfdb_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire cfdb_pkg::in_item_t        item_i,
  input  wire logic [cfdb_pkg::ByteW-1:0] header_i,
  output logic                           res_valid_o,
  output cfdb_pkg::result_t              res_o
);
  import cfdb_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] chk_q, chk_d;
  logic [ByteW-1:0] seq_q, seq_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] st_q, st_d;
  logic [ByteW-1:0] count_inc;
  logic [ByteW-1:0] b;
  logic             in_packet;

  assign b         = item_i.byte_value;
  assign count_inc = count_q + 8'd1;
  assign in_packet = (phase_q != PH_IDLE) && (phase_q != PH_SKIP);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    chk_d   = chk_q;
    seq_d   = seq_q;
    cmd_d   = cmd_q;
    st_d    = st_q;

    res_valid_o          = 1'b0;
    res_o.kind           = KIND_SUMMARY;
    res_o.data_byte      = '0;
    res_o.data_index     = '0;
    res_o.seq_number     = seq_q;
    res_o.command_code   = cmd_q;
    res_o.state_code     = st_q;
    res_o.payload_length = len_q;
    res_o.status         = ST_OK;

    if (step_i) begin
      if (item_i.start_of_packet) begin
        // A start mark inside a packet closes it as truncated; that result
        // takes the slot, so a bad header of the new packet goes unreported.
        if (in_packet) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_TRUNC;
        end else if (b != header_i) begin
          res_valid_o          = 1'b1;
          res_o.status         = ST_BADHEAD;
          res_o.seq_number     = '0;
          res_o.command_code   = '0;
          res_o.state_code     = '0;
          res_o.payload_length = '0;
        end
        count_d = '0;
        len_d   = '0;
        chk_d   = '0;
        seq_d   = '0;
        cmd_d   = '0;
        st_d    = '0;
        phase_d = (b == header_i) ? PH_SEQ : PH_SKIP;
      end else begin
        unique case (phase_q) inside
          PH_SEQ: begin
            seq_d   = b;
            phase_d = PH_CMD;
          end
          PH_CMD: begin
            cmd_d   = b;
            phase_d = PH_STATE;
          end
          PH_STATE: begin
            st_d    = b;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            len_d   = b;
            count_d = '0;
            phase_d = (b == '0) ? PH_CHECK : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_DATA;
            res_o.data_byte  = b;
            res_o.data_index = count_q;
            chk_d            = chk_q ^ b;
            count_d          = count_inc;
            if (count_inc >= len_q) begin
              phase_d = PH_CHECK;
            end
          end
          PH_CHECK: begin
            res_valid_o  = 1'b1;
            res_o.status = (b == chk_q) ? ST_OK : ST_MISMATCH;
            phase_d      = PH_IDLE;
          end
          PH_IDLE, PH_SKIP: begin
            phase_d = phase_q;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      len_q   <= '0;
      chk_q   <= '0;
      seq_q   <= '0;
      cmd_q   <= '0;
      st_q    <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      chk_q   <= chk_d;
      seq_q   <= seq_d;
      cmd_q   <= cmd_d;
      st_q    <= st_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/cfdb_out_stage.sv
`default_nettype none
module cfdb_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire cfdb_pkg::result_t res_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cfdb_pkg::result_t      res_o
);
  import cfdb_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Room for a new result when empty or when the held one leaves this cycle.
  assign room_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (room_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (room_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

FILE: sim/command_frame_deframer_bcc_tb.sv
`timescale 1ns / 100ps

module command_frame_deframer_bcc_tb;
  import cfdb_pkg::*;

  // The time through the block, plus some margin for an item still inside it
  // that causes no result (a header, sequence or length byte, for example).
  localparam int unsigned DutLatency   = 2;
  localparam int unsigned SettleCycles = DutLatency + 6;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned LongStall    = 400;
  localparam int unsigned PhaseItems   = 400;
  localparam int unsigned NumPhases    = 5;
  localparam int unsigned NumRows      = 25;
  localparam int unsigned MaxReports   = 10;

  localparam result_t NO_RESULT = '0;

  // Receiver behavior, chosen per segment of random length.
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_ONE_IN_FOUR,
    RX_MOSTLY
  } rx_mode_e;

  // One row of the directed part. When has_typed is set, the result is
  // written out by hand and replaces the predicted one.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       sop;
    logic       has_typed;
    result_t    typed;
  } stim_row_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [7:0]  cfg_data_i    = 8'h00;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_ready_o;

  // Deframer state as the testbench sees it.
  logic [7:0] hdr_expected = 8'h00;
  phase_e     pkt_phase    = PH_IDLE;
  logic [7:0] pay_count    = 8'h00;
  logic [7:0] pay_len      = 8'h00;
  logic [7:0] bcc_accum    = 8'h00;
  logic [7:0] cap_seq      = 8'h00;
  logic [7:0] cap_cmd      = 8'h00;
  logic [7:0] cap_state    = 8'h00;

  // Results waiting to come out of the block, oldest first.
  result_t expected_results[$];

  stim_row_t stim_table [NumRows];

  int unsigned bytes_sent     = 0;
  int unsigned counted_items  = 0;
  int unsigned burst_left     = 0;
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned data_seen      = 0;
  int unsigned header_writes  = 0;
  int unsigned status_seen [4];
  int unsigned stall_req      = 0;
  int unsigned cycles;

  always #10 clk_i = ~clk_i;

  command_frame_deframer_bcc u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Summary item built from the fields captured so far.
  function automatic result_t packet_summary(status_e st);
    return '{KIND_SUMMARY, 8'h00, 8'h00, cap_seq, cap_cmd, cap_state, pay_len, st};
  endfunction

  // Advances the deframer state by one received byte. Returns 1 when the byte
  // causes a result, which is then placed in res. Bytes that only get ignored
  // (no start mark while idle or skipping) are not counted as work.
  function automatic bit deframe_step(input logic [7:0] rx_byte, input logic sop,
                                      output result_t res);
    bit got;
    got = 1'b0;
    res = NO_RESULT;
    if (sop) begin
      // A start mark inside a packet closes it as truncated. The same byte
      // then opens the next packet; a bad header there stays silent, since
      // the one result of this step is already taken.
      if (pkt_phase != PH_IDLE && pkt_phase != PH_SKIP) begin
        res = packet_summary(ST_TRUNC);
        got = 1'b1;
      end
      pay_count = 8'h00;
      pay_len   = 8'h00;
      bcc_accum = 8'h00;
      cap_seq   = 8'h00;
      cap_cmd   = 8'h00;
      cap_state = 8'h00;
      if (rx_byte == hdr_expected) begin
        pkt_phase = PH_SEQ;
      end else begin
        pkt_phase = PH_SKIP;
        if (!got) begin
          res = packet_summary(ST_BADHEAD);
          got = 1'b1;
        end
      end
      counted_items++;
      return got;
    end
    if (pkt_phase != PH_IDLE && pkt_phase != PH_SKIP) counted_items++;
    case (pkt_phase)
      PH_SEQ: begin
        cap_seq   = rx_byte;
        pkt_phase = PH_CMD;
      end
      PH_CMD: begin
        cap_cmd   = rx_byte;
        pkt_phase = PH_STATE;
      end
      PH_STATE: begin
        cap_state = rx_byte;
        pkt_phase = PH_LEN;
      end
      PH_LEN: begin
        // A zero length goes straight to the check byte, checked against 0.
        pay_len   = rx_byte;
        pay_count = 8'h00;
        pkt_phase = (rx_byte == 8'h00) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res = '{KIND_DATA, rx_byte, pay_count, cap_seq, cap_cmd, cap_state, pay_len,
                ST_OK};
        got       = 1'b1;
        bcc_accum = bcc_accum ^ rx_byte;
        pay_count = pay_count + 8'd1;
        if (pay_count >= pay_len) pkt_phase = PH_CHECK;
      end
      PH_CHECK: begin
        res       = packet_summary((rx_byte == bcc_accum) ? ST_OK : ST_MISMATCH);
        got       = 1'b1;
        pkt_phase = PH_IDLE;
      end
      default: begin
      end
    endcase
    return got;
  endfunction

  // Offers one byte on the input channel and waits until the block takes it.
  // The sender works in bursts; between bursts tvalid drops for a random pause.
  // A burst may follow the previous one with no gap at all.
  task automatic send_byte(input logic [7:0] rx_byte, input logic sop,
                           input logic has_typed, input result_t typed);
    result_t res;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx_byte;
    s_axis_tuser  <= sop;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (deframe_step(rx_byte, sop, res) || has_typed)
      expected_results.push_back(has_typed ? typed : res);
  endtask

  // Stops offering items and waits until every expected result is out, then a
  // little longer for bytes inside the block that cause no result.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Header byte write; only called with the input paused and all results out.
  task automatic write_header(input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    hdr_expected = value;
    header_writes++;
  endtask

  // One random packet. Most are well formed with the current header and a
  // short payload; a few carry a long or maximal payload. The rest are broken:
  // a wrong header, a wrong check byte, a packet cut short by the next start
  // mark, or loose bytes with no start mark at all.
  task automatic send_packet();
    logic [7:0] pkt[$];
    logic [7:0] hdr;
    logic [7:0] len;
    logic [7:0] bcc;
    int unsigned pick;
    int unsigned keep;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
      return;
    end
    hdr  = (pick < 14) ? 8'($urandom) : hdr_expected;
    pick = $urandom_range(0, 99);
    if (pick < 2) len = 8'hFF;
    else if (pick < 6) len = 8'($urandom_range(13, 254));
    else len = 8'($urandom_range(0, 12));
    pkt = {hdr, 8'($urandom), 8'($urandom), 8'($urandom), len};
    bcc = 8'h00;
    repeat (len) begin
      pkt.push_back(8'($urandom));
      bcc = bcc ^ pkt[$];
    end
    pkt.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : bcc);
    keep = pkt.size();
    if ($urandom_range(0, 99) < 12) keep = $urandom_range(1, pkt.size() - 1);
    for (int i = 0; i < keep; i++) send_byte(pkt[i], (i == 0), 1'b0, NO_RESULT);
  endtask

  // Result checker and receiver. Each result taken off m_axis is compared with
  // the oldest expectation; then tready for the next cycle is chosen. A long
  // hold-off requested by the stimulus side overrides the normal pattern, so
  // that the block fills up and pushes back on its input.
  always @(posedge clk_i) begin : rx_side
    static rx_mode_e    rx_mode     = RX_ALWAYS;
    static int unsigned seg_left    = 0;
    static int unsigned rx_tick     = 0;
    static int unsigned stall_seen  = 0;
    static int unsigned stall_left  = 0;
    result_t act;
    result_t exp_res;
    logic    ready_next;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act.kind           = kind_e'(m_axis_tuser);
      act.data_byte      = m_axis_tdata[7:0];
      act.data_index     = m_axis_tdata[15:8];
      act.seq_number     = m_axis_tdata[23:16];
      act.command_code   = m_axis_tdata[31:24];
      act.state_code     = m_axis_tdata[39:32];
      act.payload_length = m_axis_tdata[47:40];
      act.status         = status_e'(m_axis_tdata[49:48]);
      results_seen++;
      if (act.kind == KIND_DATA) data_seen++;
      else status_seen[act.status]++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("ERROR at %0t: result with nothing expected: kind=%0d byte=%02h",
                   $realtime, act.kind, act.data_byte);
      end else begin
        exp_res = expected_results.pop_front();
        if (act !== exp_res || m_axis_tdata[55:50] !== 6'd0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("ERROR at %0t: result %0d differs", $realtime, results_seen);
            $display("  expected kind=%0d byte=%02h idx=%0d seq=%02h cmd=%02h st=%02h len=%0d status=%0d",
                     exp_res.kind, exp_res.data_byte, exp_res.data_index,
                     exp_res.seq_number, exp_res.command_code, exp_res.state_code,
                     exp_res.payload_length, exp_res.status);
            $display("  actual   kind=%0d byte=%02h idx=%0d seq=%02h cmd=%02h st=%02h len=%0d status=%0d pad=%02h",
                     act.kind, act.data_byte, act.data_index, act.seq_number,
                     act.command_code, act.state_code, act.payload_length,
                     act.status, m_axis_tdata[55:50]);
          end
        end
      end
    end

    rx_tick++;
    if (stall_seen != stall_req) begin
      stall_seen = stall_req;
      stall_left = LongStall;
    end
    if (stall_left != 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        rx_mode  = rx_mode_e'($urandom_range(0, 3));
      end
      seg_left--;
      case (rx_mode)
        RX_ALWAYS:      ready_next = 1'b1;
        RX_COIN:        ready_next = $urandom_range(0, 1);
        RX_ONE_IN_FOUR: ready_next = (rx_tick % 4 == 0);
        default:        ready_next = ($urandom_range(0, 9) != 0);
      endcase
    end
    m_axis_tready <= ready_next;
  end

  // Watchdog: a run that hangs ends here as a failure.
  initial begin
    for (cycles = 0; cycles < CycleLimit; cycles++) @(posedge clk_i);
    $display("ERROR: no finish after %0d cycles, %0d results still expected",
             CycleLimit, expected_results.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    // Directed part, run with the header byte at its reset value of zero:
    // a loose byte while idle, a bad header and a byte skipped after it, a
    // zero-length packet with all-ones fields, a two-byte payload with a wrong
    // check, a start mark inside a packet that opens a good packet, and a start
    // mark that cuts off a packet of maximal declared length with a bad header.
    stim_table = '{
      '{8'h55, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b1,
        '{KIND_SUMMARY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ST_BADHEAD}},
      '{8'h12, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1,
        '{KIND_SUMMARY, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, ST_OK}},
      '{8'h00, 1'b1, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'h80, 1'b0, 1'b0, NO_RESULT},
      '{8'h7F, 1'b0, 1'b0, NO_RESULT},
      '{8'h02, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h0F, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1,
        '{KIND_SUMMARY, 8'h00, 8'h00, 8'h01, 8'h80, 8'h7F, 8'h02, ST_MISMATCH}},
      '{8'h00, 1'b1, 1'b0, NO_RESULT},
      '{8'h33, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b1,
        '{KIND_SUMMARY, 8'h00, 8'h00, 8'h33, 8'h00, 8'h00, 8'h00, ST_TRUNC}},
      '{8'h44, 1'b0, 1'b0, NO_RESULT},
      '{8'h55, 1'b0, 1'b0, NO_RESULT},
      '{8'h66, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h99, 1'b1, 1'b1,
        '{KIND_SUMMARY, 8'h00, 8'h00, 8'h44, 8'h55, 8'h66, 8'hFF, ST_TRUNC}}
    };

    // Single reset at the start of the run.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i])
      send_byte(stim_table[i].rx_byte, stim_table[i].sop, stim_table[i].has_typed,
                stim_table[i].typed);

    // Random part in phases, each with its own header byte, the extremes
    // among them. Every phase begins with the sender paused until all results
    // are in. In the third phase the receiver holds off for a long stretch
    // while the sender keeps offering bytes.
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      case (p)
        0:       write_header(8'hFF);
        1:       write_header(8'h00);
        4:       write_header(8'hA5);
        default: write_header(8'($urandom));
      endcase
      if (p == 2) stall_req <= stall_req + 1;
      counted_items = 0;
      while (counted_items < PhaseItems) send_packet();
    end

    drain_results();

    $display("Sent %0d bytes in %0d header settings; %0d results, %0d of them payload bytes",
             bytes_sent, header_writes + 1, results_seen, data_seen);
    $display("Summaries: ok %0d, bad header %0d, check mismatch %0d, truncated %0d",
             status_seen[ST_OK], status_seen[ST_BADHEAD], status_seen[ST_MISMATCH],
             status_seen[ST_TRUNC]);
    if (expected_results.size() != 0)
      $display("ERROR: %0d expected results never arrived", expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/cfdb_pkg.sv
src/cfdb_in_stage.sv
src/cfdb_parser.sv
src/cfdb_out_stage.sv
src/command_frame_deframer_bcc.sv
sim/command_frame_deframer_bcc_tb.sv
